[rtl/core/salc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int WAYS           = 8;
  localparam int MAX_INDEX_BITS = 10;
  localparam int COUNT_WIDTH    = 40;

  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 30;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_WAY_W   = 3;
  localparam int OUT_COUNT_W = 40;
  localparam int SHIFT_W     = 6;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int SETS  = 1 << MAX_INDEX_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = CFG_W'(6);
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = CFG_W'(10);
  localparam logic [CFG_W-1:0] OFFSET_BITS_MIN = CFG_W'(2);
  localparam logic [CFG_W-1:0] OFFSET_BITS_MAX = CFG_W'(12);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][WAY_W-1:0] lru;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic             filled;
    logic             wb;
    logic [WAY_W-1:0] way;
  } lookup_res_t;

  typedef struct packed {
    logic access;
    logic hit;
    logic wb;
  } stat_upd_t;

  function automatic row_t reset_row();
    row_t r;
    r = '0;
    for (int j = 0; j < WAYS; j++) begin
      r.lru[j] = WAY_W'(j);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/salc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/salc_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_lookup (
  input  wire salc_pkg::row_t                  row_i,
  input  wire logic [salc_pkg::TAG_W-1:0]      tag_i,
  input  wire logic                            wr_i,
  output salc_pkg::row_t                       row_o,
  output salc_pkg::lookup_res_t                res_o
);

  logic                         hit;
  logic                         found;
  logic                         pos_found;
  logic [salc_pkg::WAY_W-1:0]   hit_way;
  logic [salc_pkg::WAY_W-1:0]   empty_way;
  logic [salc_pkg::WAY_W-1:0]   victim;
  logic [salc_pkg::WAY_W-1:0]   way;
  logic [salc_pkg::WAY_W-1:0]   pos;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    found   = 1'b0;
    empty_way = '0;
    for (int j = 0; j < salc_pkg::WAYS; j++) begin
      if (!hit && row_i.valid[j] && row_i.tag[j] == tag_i) begin
        hit     = 1'b1;
        hit_way = salc_pkg::WAY_W'(j);
      end
      if (!found && !row_i.valid[j]) begin
        found     = 1'b1;
        empty_way = salc_pkg::WAY_W'(j);
      end
    end
    victim = row_i.lru[0];
    way    = hit ? hit_way : (found ? empty_way : victim);

    res_o.hit    = hit;
    res_o.filled = !hit && found;
    res_o.wb     = !hit && !found && row_i.dirty[victim];
    res_o.way    = way;

    row_o = row_i;
    if (hit) begin
      if (wr_i) begin
        row_o.dirty[way] = 1'b1;
      end
    end else begin
      row_o.tag[way]   = tag_i;
      row_o.valid[way] = 1'b1;
      row_o.dirty[way] = wr_i;
    end

    // move the used way to the most recent end of the order
    pos       = salc_pkg::WAY_W'(salc_pkg::WAYS - 1);
    pos_found = 1'b0;
    for (int j = 0; j < salc_pkg::WAYS; j++) begin
      if (!pos_found && row_i.lru[j] == way) begin
        pos_found = 1'b1;
        pos       = salc_pkg::WAY_W'(j);
      end
    end
    for (int j = 0; j < salc_pkg::WAYS - 1; j++) begin
      row_o.lru[j] = (salc_pkg::WAY_W'(j) < pos) ? row_i.lru[j] : row_i.lru[j+1];
    end
    row_o.lru[salc_pkg::WAYS-1] = way;
  end

endmodule

`default_nettype wire

[rtl/core/salc_stats.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_stats (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire salc_pkg::stat_upd_t                 upd_i,
  output logic [salc_pkg::COUNT_WIDTH-1:0]         access_cnt_o,
  output logic [salc_pkg::COUNT_WIDTH-1:0]         hit_cnt_o,
  output logic [salc_pkg::COUNT_WIDTH-1:0]         wb_cnt_o
);

  logic [salc_pkg::COUNT_WIDTH-1:0] access_cnt_r, access_cnt_nxt;
  logic [salc_pkg::COUNT_WIDTH-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [salc_pkg::COUNT_WIDTH-1:0] wb_cnt_r, wb_cnt_nxt;

  function automatic logic [salc_pkg::COUNT_WIDTH-1:0] sat_inc(
    input logic [salc_pkg::COUNT_WIDTH-1:0] v
  );
    return (v == salc_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  always_comb begin
    access_cnt_nxt = upd_i.access ? sat_inc(access_cnt_r) : access_cnt_r;
    hit_cnt_nxt    = upd_i.hit    ? sat_inc(hit_cnt_r)    : hit_cnt_r;
    wb_cnt_nxt     = upd_i.wb     ? sat_inc(wb_cnt_r)     : wb_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_cnt_r <= '0;
      hit_cnt_r    <= '0;
      wb_cnt_r     <= '0;
    end else begin
      access_cnt_r <= access_cnt_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      wb_cnt_r     <= wb_cnt_nxt;
    end
  end

  assign access_cnt_o = access_cnt_r;
  assign hit_cnt_o    = hit_cnt_r;
  assign wb_cnt_o     = wb_cnt_r;

endmodule

`default_nettype wire

[rtl/core/set_assoc_lru_cache_model.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tag-only model of an 8-way set-associative, write-back, write-allocate
// cache with true LRU order per set. One access is taken per clock cycle
// unless in_stall is high, as when a held result blocks the lookup stage;
// an access is registered there and its result in the output registers.
// The rate comes from the set row RAM: each set's tags, valid and dirty bits
// and LRU order sit in one row that is read when the access is accepted,
// compared against all ways in parallel in the next cycle and written back
// once the access leaves the lookup stage; the row just written is forwarded
// to the next access on the same set. After reset it sweeps 1024 rows once
// to clear them, one per cycle, in_stall high; cfg writes are taken any time.
module set_assoc_lru_cache_model (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,

  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_action,
  input  wire logic [salc_pkg::ADDR_W-1:0]          in_address,

  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_hit,
  output logic                                      out_filled_empty,
  output logic                                      out_wrote_back,
  output logic [salc_pkg::OUT_WAY_W-1:0]            out_way_used,
  output logic [salc_pkg::OUT_COUNT_W-1:0]          out_access_count,
  output logic [salc_pkg::OUT_COUNT_W-1:0]          out_hit_count,
  output logic [salc_pkg::OUT_COUNT_W-1:0]          out_writeback_count,

  input  wire logic                                 cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [salc_pkg::CFG_W-1:0]   offset_bits_r;
  logic [salc_pkg::CFG_W-1:0]   index_bits_r;
  logic [salc_pkg::SHIFT_W-1:0] ob;
  logic [salc_pkg::SHIFT_W-1:0] ib;
  logic [salc_pkg::ADDR_W-1:0]  idx_mask;
  logic [salc_pkg::SET_W-1:0]   in_set;
  logic [salc_pkg::TAG_W-1:0]   in_tag;

  logic                         clearing_r;
  logic [salc_pkg::SET_W-1:0]   clr_cnt_r;

  logic                         s1_valid_r;
  logic                         s1_wr_r;
  logic [salc_pkg::TAG_W-1:0]   s1_tag_r;
  logic [salc_pkg::SET_W-1:0]   s1_set_r;
  logic                         s1_adv;
  logic                         accept;

  logic                         fwd_valid_r;
  logic [salc_pkg::SET_W-1:0]   fwd_set_r;
  salc_pkg::row_t               fwd_row_r;

  logic [salc_pkg::ROW_W-1:0]   ram_rdata;
  logic                         ram_we;
  logic [salc_pkg::SET_W-1:0]   ram_waddr;
  logic [salc_pkg::ROW_W-1:0]   ram_wdata;

  salc_pkg::row_t               row_cur;
  salc_pkg::row_t               row_new;
  salc_pkg::lookup_res_t        res;
  salc_pkg::stat_upd_t          upd;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic                         out_filled_r;
  logic                         out_wb_r;
  logic [salc_pkg::WAY_W-1:0]   out_way_r;

  logic [salc_pkg::COUNT_WIDTH-1:0] access_cnt;
  logic [salc_pkg::COUNT_WIDTH-1:0] hit_cnt;
  logic [salc_pkg::COUNT_WIDTH-1:0] wb_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= salc_pkg::OFFSET_BITS_RST;
      index_bits_r  <= salc_pkg::INDEX_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        salc_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (offset_bits_r < salc_pkg::OFFSET_BITS_MIN) begin
      ob = salc_pkg::SHIFT_W'(salc_pkg::OFFSET_BITS_MIN);
    end else if (offset_bits_r > salc_pkg::OFFSET_BITS_MAX) begin
      ob = salc_pkg::SHIFT_W'(salc_pkg::OFFSET_BITS_MAX);
    end else begin
      ob = salc_pkg::SHIFT_W'(offset_bits_r);
    end
    if (salc_pkg::SHIFT_W'(index_bits_r) > salc_pkg::SHIFT_W'(salc_pkg::MAX_INDEX_BITS)) begin
      ib = salc_pkg::SHIFT_W'(salc_pkg::MAX_INDEX_BITS);
    end else begin
      ib = salc_pkg::SHIFT_W'(index_bits_r);
    end
    idx_mask = ~({salc_pkg::ADDR_W{1'b1}} << ib);
    in_set   = salc_pkg::SET_W'((in_address >> ob) & idx_mask);
    in_tag   = salc_pkg::TAG_W'(in_address >> (ob + ib));
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == salc_pkg::SET_W'(salc_pkg::SETS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r  <= in_action;
      s1_tag_r <= in_tag;
      s1_set_r <= in_set;
    end
  end

  assign ram_we    = clearing_r || s1_adv;
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_set_r;
  assign ram_wdata = clearing_r ? salc_pkg::reset_row() : row_new;

  salc_ram #(
    .WIDTH (salc_pkg::ROW_W),
    .DEPTH (salc_pkg::SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // take the row written on the edge this access was read
  assign row_cur = (fwd_valid_r && fwd_set_r == s1_set_r) ? fwd_row_r
                                                          : salc_pkg::row_t'(ram_rdata);

  salc_lookup u_lookup (
    .row_i (row_cur),
    .tag_i (s1_tag_r),
    .wr_i  (s1_wr_r),
    .row_o (row_new),
    .res_o (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_adv) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_set_r <= s1_set_r;
      fwd_row_r <= row_new;
    end
  end

  always_comb begin
    upd.access = s1_adv;
    upd.hit    = s1_adv && res.hit;
    upd.wb     = s1_adv && res.wb;
  end

  salc_stats u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd_i        (upd),
    .access_cnt_o (access_cnt),
    .hit_cnt_o    (hit_cnt),
    .wb_cnt_o     (wb_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r    <= res.hit;
      out_filled_r <= res.filled;
      out_wb_r     <= res.wb;
      out_way_r    <= res.way;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_filled_empty    = out_filled_r;
  assign out_wrote_back      = out_wb_r;
  assign out_way_used        = salc_pkg::OUT_WAY_W'(out_way_r);
  assign out_access_count    = salc_pkg::OUT_COUNT_W'(access_cnt);
  assign out_hit_count       = salc_pkg::OUT_COUNT_W'(hit_cnt);
  assign out_writeback_count = salc_pkg::OUT_COUNT_W'(wb_cnt);

endmodule

`default_nettype wire
